FILE: rtl/core/psdc_pkg.sv
package psdc_pkg;

  // Number of duration buckets; class codes and counts stay 4 bits wide.
  localparam int unsigned NUM_BUCKETS = 15;
  localparam int unsigned IDX_W       = 4;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t        CLASS_OVF = 4'hF;
  localparam logic [15:0] SIG_HITS  = 16'd2;

  // Input command codes.
  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // Data type codes.
  localparam logic [1:0] DT_SPACE = 2'd0;
  localparam logic [1:0] DT_PULSE = 2'd1;
  localparam logic [1:0] DT_BOTH  = 2'd2;

  typedef struct packed {
    logic [15:0] low;
    logic [15:0] high;
    logic [15:0] hits;
    logic [15:0] phits;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear;
    logic cls_start;
    logic sel_space;
    logic upd;
    logic dt_start;
    logic dt_latch;
  } dp_cmd_t;

  typedef struct packed {
    logic pass_done;
  } dp_stat_t;

  // Matching tolerance grows with the duration.
  function automatic logic [10:0] tol_of(input logic [15:0] v);
    logic [10:0] t;
    if (v < 16'd1000) begin
      t = 11'd150;
    end else if (v < 16'd2000) begin
      t = 11'd200;
    end else if (v < 16'd3000) begin
      t = 11'd300;
    end else if (v < 16'd4000) begin
      t = 11'd400;
    end else if (v < 16'd5000) begin
      t = 11'd600;
    end else begin
      t = 11'd2000;
    end
    return t;
  endfunction

endpackage

FILE: rtl/core/psdc_dp.sv
module psdc_dp (
  input  logic               clk,
  input  logic               rst,
  input  psdc_pkg::dp_cmd_t  dcmd,
  output psdc_pkg::dp_stat_t dstat,
  input  logic [15:0]        pulse_us,
  input  logic [15:0]        space_us,
  output logic [3:0]         pulse_class,
  output logic [3:0]         space_class,
  output logic [3:0]         buckets_used,
  output logic [1:0]         data_type
);

  psdc_pkg::entry_t mem [psdc_pkg::NUM_BUCKETS];
  psdc_pkg::entry_t rd_data;
  psdc_pkg::entry_t sel;
  psdc_pkg::entry_t wr_data;

  psdc_pkg::idx_t count;
  psdc_pkg::idx_t idx;
  psdc_pkg::idx_t chk_idx;
  psdc_pkg::idx_t sel_idx;
  psdc_pkg::idx_t wr_idx;
  psdc_pkg::idx_t new_cls;
  psdc_pkg::idx_t pc;
  psdc_pkg::idx_t sc;

  logic        active;
  logic        chk_v;
  logic        mode_dt;
  logic        hit_f;
  logic        near_f;
  logic        wr_en;
  logic        grow;
  logic        hit;
  logic [15:0] span;
  logic [15:0] best_dist;
  logic [15:0] pulse_r;
  logic [15:0] space_r;
  logic [15:0] val;
  logic [10:0] tol;
  logic [15:0] sp_hits;
  logic [3:0]  pcls;
  logic [3:0]  scls;
  logic [1:0]  dtype;

  assign dstat.pass_done = !active && !chk_v;

  assign pulse_class  = pcls;
  assign space_class  = scls;
  assign buckets_used = count;
  assign data_type    = dtype;

  // Compare stage, one entry per cycle.
  assign hit  = (rd_data.low <= val) && (val <= rd_data.high);
  assign span = (val < rd_data.low) ? (rd_data.low - val) : (val - rd_data.high);
  assign sp_hits = (rd_data.hits >= rd_data.phits) ? (rd_data.hits - rd_data.phits) : 16'd0;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = sel_idx;
    wr_data = sel;
    new_cls = psdc_pkg::CLASS_OVF;
    grow    = 1'b0;
    if (dcmd.upd) begin
      if (hit_f || near_f) begin
        wr_en         = 1'b1;
        wr_data.low   = (val < sel.low) ? val : sel.low;
        wr_data.high  = (val > sel.high) ? val : sel.high;
        wr_data.hits  = sel.hits + 16'd1;
        wr_data.phits = dcmd.sel_space ? sel.phits : sel.phits + 16'd1;
        new_cls       = sel_idx;
      end else if (count < psdc_pkg::idx_t'(psdc_pkg::NUM_BUCKETS)) begin
        wr_en         = 1'b1;
        wr_idx        = count;
        wr_data.low   = val;
        wr_data.high  = val;
        wr_data.hits  = 16'd1;
        wr_data.phits = dcmd.sel_space ? 16'd0 : 16'd1;
        new_cls       = count;
        grow          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (active) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      chk_v  <= 1'b0;
      count  <= '0;
    end else begin
      chk_v <= active;
      if (dcmd.cls_start || dcmd.dt_start) begin
        active <= (count != '0);
      end else if (active && (idx == count - 4'd1)) begin
        active <= 1'b0;
      end
      if (dcmd.clear) begin
        count <= '0;
      end else if (grow) begin
        count <= count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (dcmd.cls_start || dcmd.dt_start) begin
      idx <= '0;
    end else if (active) begin
      idx <= idx + 4'd1;
    end

    if (dcmd.accept) begin
      pulse_r <= pulse_us;
      space_r <= space_us;
      pcls    <= '0;
      scls    <= '0;
    end

    if (dcmd.cls_start) begin
      mode_dt <= 1'b0;
      hit_f   <= 1'b0;
      near_f  <= 1'b0;
      val     <= dcmd.sel_space ? space_r : pulse_r;
      tol     <= psdc_pkg::tol_of(dcmd.sel_space ? space_r : pulse_r);
    end else if (dcmd.dt_start) begin
      mode_dt <= 1'b1;
      pc      <= '0;
      sc      <= '0;
    end else if (chk_v && mode_dt) begin
      pc <= pc + ((rd_data.phits >= psdc_pkg::SIG_HITS) ? 4'd1 : 4'd0);
      sc <= sc + ((sp_hits >= psdc_pkg::SIG_HITS) ? 4'd1 : 4'd0);
    end else if (chk_v && !hit_f) begin
      // The first window hit wins; otherwise the strictly nearest edge in tolerance.
      if (hit) begin
        hit_f   <= 1'b1;
        sel     <= rd_data;
        sel_idx <= chk_idx;
      end else if ((span <= {5'd0, tol}) && (!near_f || (span < best_dist))) begin
        near_f    <= 1'b1;
        best_dist <= span;
        sel       <= rd_data;
        sel_idx   <= chk_idx;
      end
    end

    if (dcmd.upd) begin
      if (dcmd.sel_space) begin
        scls <= new_cls;
      end else begin
        pcls <= new_cls;
      end
    end

    if (dcmd.dt_latch) begin
      if ((pc <= 4'd1) && (sc >= 4'd2)) begin
        dtype <= psdc_pkg::DT_SPACE;
      end else if ((sc <= 4'd1) && (pc >= 4'd2)) begin
        dtype <= psdc_pkg::DT_PULSE;
      end else begin
        dtype <= psdc_pkg::DT_BOTH;
      end
    end
  end

  a_chk_in_range: assert property (@(posedge clk) disable iff (rst)
    chk_v |-> (chk_idx < count))
    else $error("compare stage holds an entry beyond the open buckets");

  a_grow_bounded: assert property (@(posedge clk) disable iff (rst)
    grow |=> (count <= psdc_pkg::idx_t'(psdc_pkg::NUM_BUCKETS)) && (count != '0))
    else $error("bucket count grew past its limit");

endmodule

FILE: rtl/core/psdc_ctrl.sv
module psdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cmd,
  output logic               busy,
  output logic               done,
  output psdc_pkg::dp_cmd_t  dcmd,
  input  psdc_pkg::dp_stat_t dstat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_START,
    S_P_SCAN,
    S_P_UPD,
    S_S_START,
    S_S_SCAN,
    S_S_UPD,
    S_D_START,
    S_D_SCAN
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    dcmd = '0;
    unique case (state)
      S_IDLE: begin
        dcmd.accept = start;
        dcmd.clear  = start && (cmd == psdc_pkg::CMD_CLEAR);
      end
      S_P_START: begin
        dcmd.cls_start = 1'b1;
      end
      S_P_UPD: begin
        dcmd.upd = 1'b1;
      end
      S_S_START: begin
        dcmd.cls_start = 1'b1;
        dcmd.sel_space = 1'b1;
      end
      S_S_UPD: begin
        dcmd.upd       = 1'b1;
        dcmd.sel_space = 1'b1;
      end
      S_D_START: begin
        dcmd.dt_start = 1'b1;
      end
      S_D_SCAN: begin
        dcmd.dt_latch = dstat.pass_done;
      end
      default: begin
        dcmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= (cmd == psdc_pkg::CMD_CLEAR) ? S_D_START : S_P_START;
          end
        end
        S_P_START: state <= S_P_SCAN;
        S_P_SCAN: begin
          if (dstat.pass_done) begin
            state <= S_P_UPD;
          end
        end
        S_P_UPD:   state <= S_S_START;
        S_S_START: state <= S_S_SCAN;
        S_S_SCAN: begin
          if (dstat.pass_done) begin
            state <= S_S_UPD;
          end
        end
        S_S_UPD:   state <= S_D_START;
        S_D_START: state <= S_D_SCAN;
        S_D_SCAN: begin
          if (dstat.pass_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

endmodule

FILE: rtl/core/pulse_space_duration_classifier.sv
// Channel   Signals                                     Handshake
// input     cmd, pulse_us, space_us                     start high while busy low
// result    pulse_class, space_class, buckets_used,     done high for one cycle
//           data_type
//
// A classify word runs a pulse, a space and a data-type pass; each pass reads the bucket
// memory one entry a cycle over the open buckets (at most 15). A clear word empties the
// bucket set and runs only the data-type pass. busy falls in the cycle done is high.
// rst (synchronous) empties the bucket set; the bucket memory itself is not cleared.
// The receiver cannot stall: done is high for one cycle only; pulse_class and space_class hold until the next word.
module pulse_space_duration_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [15:0] pulse_us,
  input  logic [15:0] space_us,
  output logic        done,
  output logic [3:0]  pulse_class,
  output logic [3:0]  space_class,
  output logic [3:0]  buckets_used,
  output logic [1:0]  data_type
);

  psdc_pkg::dp_cmd_t  dcmd;
  psdc_pkg::dp_stat_t dstat;

  psdc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .dcmd  (dcmd),
    .dstat (dstat)
  );

  psdc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .dcmd         (dcmd),
    .dstat        (dstat),
    .pulse_us     (pulse_us),
    .space_us     (space_us),
    .pulse_class  (pulse_class),
    .space_class  (space_class),
    .buckets_used (buckets_used),
    .data_type    (data_type)
  );

endmodule
